/* rtl/core/ryp_pkg.sv */
// Shared constants and types for the RGB to BT.601 Y/Pb/Pr converter.
// No dependencies; every other file of the block depends on this package.
package ryp_pkg;

  localparam int COMP_W  = 16;               // component and result width
  localparam int LANES   = 3;                // Y, Pb, Pr
  localparam int COEF_W  = 20;               // matrix coefficients in millionths
  localparam int PROD_W  = COMP_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;       // signed three-term sum
  localparam int MAG_W   = 36;               // magnitude of a sum, at most 1e6 * 65535
  localparam int DC_MUL  = 15625;            // half the divisor per unit of component_max
  localparam int DC_W    = 30;
  localparam int DIV_W   = DC_W + 1;         // divisor 31250 * component_max
  localparam int NUM_SH  = 10;               // numerator is 1024 * sum + 15625 * max
  localparam int NUM_W   = 47;
  localparam int Q_W     = 16;               // quotient bits below the saturation check
  localparam int DIV_STAGES = Q_W + 2;       // numerator stage, range check, one per bit

  localparam logic [COMP_W-1:0] COMP_MAX_RST = COMP_W'(255);
  localparam logic [COMP_W-1:0] LUMA_MAX     = COMP_W'(32768);
  localparam logic [COMP_W-1:0] CHROMA_MAX   = COMP_W'(16384);

  // Lane order within every per-lane vector
  localparam int LANE_Y  = 0;
  localparam int LANE_PB = 1;
  localparam int LANE_PR = 2;

  // BT.601 matrix magnitudes in millionths; signs are applied in the sums
  localparam logic [COEF_W-1:0] CY_R = COEF_W'(299000);
  localparam logic [COEF_W-1:0] CY_G = COEF_W'(587000);
  localparam logic [COEF_W-1:0] CY_B = COEF_W'(114000);
  localparam logic [COEF_W-1:0] CB_R = COEF_W'(168736);
  localparam logic [COEF_W-1:0] CB_G = COEF_W'(331264);
  localparam logic [COEF_W-1:0] CB_B = COEF_W'(500000);
  localparam logic [COEF_W-1:0] CR_R = COEF_W'(500000);
  localparam logic [COEF_W-1:0] CR_G = COEF_W'(418688);
  localparam logic [COEF_W-1:0] CR_B = COEF_W'(81312);

  typedef struct packed {
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [DC_W-1:0]             dc;
  } ryp_mat_t;

  typedef struct packed {
    logic [LANES-1:0]          neg;
    logic [LANES-1:0]          sat;
    logic [LANES-1:0][Q_W-1:0] quo;
  } ryp_quo_t;

endpackage

/* rtl/core/ryp_rgb_if.sv */
// Valid/ready channel carrying one RGB pixel item.
// Depends on ryp_pkg for the component width.
interface ryp_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [ryp_pkg::COMP_W-1:0] red;
  logic [ryp_pkg::COMP_W-1:0] green;
  logic [ryp_pkg::COMP_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* rtl/core/ryp_ypbpr_if.sv */
// Valid/ready channel carrying one Y/Pb/Pr result item.
// Depends on ryp_pkg for the result width.
interface ryp_ypbpr_if;
  logic                              valid;
  logic                              ready;
  logic        [ryp_pkg::COMP_W-1:0] luma;
  logic signed [ryp_pkg::COMP_W-1:0] chroma_blue;
  logic signed [ryp_pkg::COMP_W-1:0] chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);
endinterface

/* rtl/core/rgb_to_ypbpr_convert.sv */
// Top level of the RGB to BT.601 Y/Pb/Pr converter and its component_max register.
// Depends on ryp_pkg, ryp_rgb_if, ryp_ypbpr_if, ryp_matrix, ryp_divider, ryp_clamp.
//
//   channel   direction  carries
//   in_pix    sink       red, green, blue (16 bit unsigned each)
//   out_pix   source     luma (16 bit unsigned), chroma_blue, chroma_red (16 bit signed)
//   cfg_*     write      component_max (16 bit), taken when cfg_we is high
//
// One item per clock while out_pix does not stall; each result passes two matrix
// stages, the 18-stage divider (numerator, range check, one per quotient bit) and
// the output register. Reset clears all valid bits and sets component_max to 255.
// A stall on out_pix holds each full stage; empty stages further up still fill.
module rgb_to_ypbpr_convert (
  input  logic                       clk,
  input  logic                       rst_n,
  ryp_rgb_if.sink                    in_pix,
  ryp_ypbpr_if.source                out_pix,
  input  logic                       cfg_we,
  input  logic [ryp_pkg::COMP_W-1:0] cfg_wdata
);
  import ryp_pkg::*;

  logic [COMP_W-1:0] comp_max_r;
  logic     mat_valid;
  logic     mat_ready;
  ryp_mat_t mat_data;
  logic     quo_valid;
  logic     quo_ready;
  ryp_quo_t quo_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_max_r <= COMP_MAX_RST;
    end else if (cfg_we) begin
      comp_max_r <= cfg_wdata;
    end
  end

  ryp_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .red       (in_pix.red),
    .green     (in_pix.green),
    .blue      (in_pix.blue),
    .comp_max  (comp_max_r),
    .out_valid (mat_valid),
    .out_ready (mat_ready),
    .out_data  (mat_data)
  );

  ryp_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mat_valid),
    .in_ready  (mat_ready),
    .in_data   (mat_data),
    .out_valid (quo_valid),
    .out_ready (quo_ready),
    .out_data  (quo_data)
  );

  ryp_clamp u_clamp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (quo_valid),
    .in_ready    (quo_ready),
    .in_data     (quo_data),
    .out_valid   (out_pix.valid),
    .out_ready   (out_pix.ready),
    .luma        (out_pix.luma),
    .chroma_blue (out_pix.chroma_blue),
    .chroma_red  (out_pix.chroma_red)
  );

endmodule

/* rtl/core/ryp_matrix.sv */
// Matrix front end: coefficient products, then signed sums split into sign and magnitude.
// Two register stages; depends on ryp_pkg.
module ryp_matrix (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ryp_pkg::COMP_W-1:0] red,
  input  logic [ryp_pkg::COMP_W-1:0] green,
  input  logic [ryp_pkg::COMP_W-1:0] blue,
  input  logic [ryp_pkg::COMP_W-1:0] comp_max,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ryp_pkg::ryp_mat_t          out_data
);
  import ryp_pkg::*;

  logic va_r;
  logic vb_r;
  logic rdy_a;
  logic rdy_b;
  logic [LANES-1:0][LANES-1:0][PROD_W-1:0] prod_r;
  logic [LANES-1:0][LANES-1:0][PROD_W-1:0] prod_nxt;
  logic [DC_W-1:0]   dc_r;
  logic [DC_W-1:0]   dc_nxt;
  logic [COMP_W-1:0] den;
  logic [LANES-1:0][SUM_W-1:0] sum;
  ryp_mat_t mat_r;
  ryp_mat_t mat_nxt;

  // A stage loads when empty or when its content moves on
  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    // a zero maximum counts as one
    den = (comp_max == '0) ? COMP_W'(1) : comp_max;
    dc_nxt = DC_W'(den) * DC_W'(DC_MUL);
    prod_nxt[LANE_Y][0]  = PROD_W'(red)   * PROD_W'(CY_R);
    prod_nxt[LANE_Y][1]  = PROD_W'(green) * PROD_W'(CY_G);
    prod_nxt[LANE_Y][2]  = PROD_W'(blue)  * PROD_W'(CY_B);
    prod_nxt[LANE_PB][0] = PROD_W'(red)   * PROD_W'(CB_R);
    prod_nxt[LANE_PB][1] = PROD_W'(green) * PROD_W'(CB_G);
    prod_nxt[LANE_PB][2] = PROD_W'(blue)  * PROD_W'(CB_B);
    prod_nxt[LANE_PR][0] = PROD_W'(red)   * PROD_W'(CR_R);
    prod_nxt[LANE_PR][1] = PROD_W'(green) * PROD_W'(CR_G);
    prod_nxt[LANE_PR][2] = PROD_W'(blue)  * PROD_W'(CR_B);
  end

  always_comb begin
    sum[LANE_Y]  = SUM_W'(prod_r[LANE_Y][0]) + SUM_W'(prod_r[LANE_Y][1])
                 + SUM_W'(prod_r[LANE_Y][2]);
    sum[LANE_PB] = SUM_W'(prod_r[LANE_PB][2]) - SUM_W'(prod_r[LANE_PB][0])
                 - SUM_W'(prod_r[LANE_PB][1]);
    sum[LANE_PR] = SUM_W'(prod_r[LANE_PR][0]) - SUM_W'(prod_r[LANE_PR][1])
                 - SUM_W'(prod_r[LANE_PR][2]);
    mat_nxt.dc = dc_r;
    for (int l = 0; l < LANES; l++) begin
      mat_nxt.neg[l] = sum[l][SUM_W-1];
      mat_nxt.mag[l] = sum[l][SUM_W-1] ? MAG_W'(-sum[l]) : MAG_W'(sum[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      prod_r <= prod_nxt;
      dc_r   <= dc_nxt;
    end
    if (rdy_b) begin
      mat_r <= mat_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_data  = mat_r;

endmodule

/* rtl/core/ryp_divider.sv */
// Pipelined restoring divider, three lanes sharing one divisor, rounding to nearest.
// One numerator stage, one range check, one stage per quotient bit; depends on ryp_pkg.
module ryp_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ryp_pkg::ryp_mat_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ryp_pkg::ryp_quo_t out_data
);
  import ryp_pkg::*;

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES:0]   rdy;
  logic [DIV_STAGES-1:0][LANES-1:0][NUM_W-1:0] rem_r;
  logic [DIV_STAGES-1:0][LANES-1:0][NUM_W-1:0] rem_nxt;
  logic [DIV_STAGES-1:0][LANES-1:0][Q_W-1:0]   quo_r;
  logic [DIV_STAGES-1:0][LANES-1:0][Q_W-1:0]   quo_nxt;
  logic [DIV_STAGES-1:0][LANES-1:0] neg_r;
  logic [DIV_STAGES-1:0][LANES-1:0] neg_nxt;
  logic [DIV_STAGES-1:0][LANES-1:0] sat_r;
  logic [DIV_STAGES-1:0][LANES-1:0] sat_nxt;
  logic [DIV_STAGES-1:0][DIV_W-1:0] div_r;
  logic [DIV_STAGES-1:0][DIV_W-1:0] div_nxt;

  // Bubbles close up: a stage takes new content when empty or when it drains
  always_comb begin
    rdy[DIV_STAGES] = out_ready;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end
  assign in_ready = rdy[0];

  always_comb begin
    logic [NUM_W-1:0] trial;
    trial = '0;
    // numerator 1024 * |sum| + 15625 * max over divisor 31250 * max
    div_nxt[0] = {in_data.dc, 1'b0};
    for (int l = 0; l < LANES; l++) begin
      rem_nxt[0][l] = NUM_W'({in_data.mag[l], {NUM_SH{1'b0}}}) + NUM_W'(in_data.dc);
      quo_nxt[0][l] = '0;
      neg_nxt[0][l] = in_data.neg[l];
      sat_nxt[0][l] = 1'b0;
    end
    // flag quotients of 2^Q_W and above: the clamp stage limits them anyway
    div_nxt[1] = div_r[0];
    for (int l = 0; l < LANES; l++) begin
      rem_nxt[1][l] = rem_r[0][l];
      quo_nxt[1][l] = '0;
      neg_nxt[1][l] = neg_r[0][l];
      sat_nxt[1][l] = rem_r[0][l] >= {div_r[0], {Q_W{1'b0}}};
    end
    // one quotient bit per stage, most significant first
    for (int s = 2; s < DIV_STAGES; s++) begin
      div_nxt[s] = div_r[s-1];
      for (int l = 0; l < LANES; l++) begin
        trial         = NUM_W'(div_r[s-1]) << (DIV_STAGES - 1 - s);
        rem_nxt[s][l] = rem_r[s-1][l];
        quo_nxt[s][l] = quo_r[s-1][l];
        neg_nxt[s][l] = neg_r[s-1][l];
        sat_nxt[s][l] = sat_r[s-1][l];
        if (rem_r[s-1][l] >= trial) begin
          rem_nxt[s][l] = rem_r[s-1][l] - trial;
          quo_nxt[s][l][DIV_STAGES-1-s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rdy[s]) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        neg_r[s] <= neg_nxt[s];
        sat_r[s] <= sat_nxt[s];
        div_r[s] <= div_nxt[s];
      end
    end
  end

  assign out_valid    = v_r[DIV_STAGES-1];
  assign out_data.quo = quo_r[DIV_STAGES-1];
  assign out_data.neg = neg_r[DIV_STAGES-1];
  assign out_data.sat = sat_r[DIV_STAGES-1];

endmodule

/* rtl/core/ryp_clamp.sv */
// Output stage: clamps the rounded quotients, applies the chroma sign, holds the result.
// One register stage; depends on ryp_pkg.
module ryp_clamp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ryp_pkg::ryp_quo_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [ryp_pkg::COMP_W-1:0] luma,
  output logic signed [ryp_pkg::COMP_W-1:0] chroma_blue,
  output logic signed [ryp_pkg::COMP_W-1:0] chroma_red
);
  import ryp_pkg::*;

  logic valid_r;
  logic rdy;
  logic [COMP_W-1:0] luma_r;
  logic [COMP_W-1:0] luma_nxt;
  logic [COMP_W-1:0] cb_r;
  logic [COMP_W-1:0] cb_nxt;
  logic [COMP_W-1:0] cr_r;
  logic [COMP_W-1:0] cr_nxt;
  logic [COMP_W-1:0] cb_mag;
  logic [COMP_W-1:0] cr_mag;

  assign rdy      = !valid_r || out_ready;
  assign in_ready = rdy;

  always_comb begin
    // luma never goes negative; drop to zero if it did
    if (in_data.neg[LANE_Y]) begin
      luma_nxt = '0;
    end else if (in_data.sat[LANE_Y] || in_data.quo[LANE_Y] > LUMA_MAX) begin
      luma_nxt = LUMA_MAX;
    end else begin
      luma_nxt = in_data.quo[LANE_Y];
    end
    cb_mag = (in_data.sat[LANE_PB] || in_data.quo[LANE_PB] > CHROMA_MAX) ?
             CHROMA_MAX : in_data.quo[LANE_PB];
    cr_mag = (in_data.sat[LANE_PR] || in_data.quo[LANE_PR] > CHROMA_MAX) ?
             CHROMA_MAX : in_data.quo[LANE_PR];
    cb_nxt = in_data.neg[LANE_PB] ? -cb_mag : cb_mag;
    cr_nxt = in_data.neg[LANE_PR] ? -cr_mag : cr_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rdy) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      luma_r <= luma_nxt;
      cb_r   <= cb_nxt;
      cr_r   <= cr_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign luma        = luma_r;
  assign chroma_blue = $signed(cb_r);
  assign chroma_red  = $signed(cr_r);

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for rgb_to_ypbpr_convert: drives RGB pixel items, predicts Y/Pb/Pr.
// Depends on ryp_pkg, ryp_rgb_if, ryp_ypbpr_if and the converter RTL.
module tb_top;
  import ryp_pkg::*;

  localparam longint SCALE_ONE   = 32768;
  localparam longint HALF_ONE    = 16384;
  localparam longint COEF_SCALE  = 1000000;
  localparam int     DRAIN_WAIT  = 25;       // pipeline is 21 deep
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    bit [COMP_W-1:0] luma;
    bit [COMP_W-1:0] chroma_blue;
    bit [COMP_W-1:0] chroma_red;
  } ypbpr_t;

  class ypbpr_scoreboard;
    bit [COMP_W-1:0] comp_max = COMP_MAX_RST;
    ypbpr_t          pending_ypbpr[$];
    int              mismatches = 0;
    int              pixels_in  = 0;
    int              results_ok = 0;

    function longint round_clamp(longint num, longint den, longint lo, longint hi);
      bit     neg;
      longint mag;
      longint q;
      longint v;
      neg = num < 0;
      mag = neg ? -num : num;
      // nearest, ties away from zero; saturate the magnitude first
      q = (2 * mag + den) / (2 * den);
      if (q > SCALE_ONE) q = SCALE_ONE;
      v = neg ? -q : q;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    function void note_pixel(bit [COMP_W-1:0] r, bit [COMP_W-1:0] g, bit [COMP_W-1:0] b);
      longint rr, gg, bb, den, ysum, pbsum, prsum;
      ypbpr_t want;
      rr = r;
      gg = g;
      bb = b;
      // a zero denominator counts as one
      den   = COEF_SCALE * ((comp_max == 0) ? 1 : longint'(comp_max));
      ysum  = 299000 * rr + 587000 * gg + 114000 * bb;
      pbsum = -168736 * rr - 331264 * gg + 500000 * bb;
      prsum = 500000 * rr - 418688 * gg - 81312 * bb;
      want.luma        = COMP_W'(round_clamp(ysum * SCALE_ONE, den, 0, SCALE_ONE));
      want.chroma_blue = COMP_W'(round_clamp(pbsum * SCALE_ONE, den, -HALF_ONE, HALF_ONE));
      want.chroma_red  = COMP_W'(round_clamp(prsum * SCALE_ONE, den, -HALF_ONE, HALF_ONE));
      pending_ypbpr.push_back(want);
      pixels_in++;
    endfunction

    function void check_result(logic [COMP_W-1:0] y, logic [COMP_W-1:0] pb,
                               logic [COMP_W-1:0] pr);
      ypbpr_t want;
      if (pending_ypbpr.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with nothing outstanding: Y=%0d Pb=%0d Pr=%0d",
                   y, $signed(pb), $signed(pr));
        return;
      end
      want = pending_ypbpr.pop_front();
      if (y !== want.luma || pb !== want.chroma_blue || pr !== want.chroma_red) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: max %0d expected Y=%0d Pb=%0d Pr=%0d, got Y=%0d Pb=%0d Pr=%0d",
                   comp_max, want.luma, $signed(want.chroma_blue),
                   $signed(want.chroma_red), y, $signed(pb), $signed(pr));
      end else begin
        results_ok++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [COMP_W-1:0] cfg_wdata;

  ryp_rgb_if   rgb_ch();
  ryp_ypbpr_if ypbpr_ch();

  rgb_to_ypbpr_convert u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (rgb_ch),
    .out_pix   (ypbpr_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ypbpr_scoreboard sb = new();
  int gap_pct   = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int settings  = 1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random back-pressure, check every accepted item
  always @(posedge clk) begin
    ypbpr_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && ypbpr_ch.valid && ypbpr_ch.ready)
      sb.check_result(ypbpr_ch.luma, ypbpr_ch.chroma_blue, ypbpr_ch.chroma_red);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("rgb_to_ypbpr_convert verification failed");
      $finish;
    end
  end

  task automatic send_pixel(bit [COMP_W-1:0] r, bit [COMP_W-1:0] g, bit [COMP_W-1:0] b);
    while ($urandom_range(99) < gap_pct) begin
      rgb_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rgb_ch.valid <= 1'b1;
    rgb_ch.red   <= r;
    rgb_ch.green <= g;
    rgb_ch.blue  <= b;
    do @(posedge clk); while (!rgb_ch.ready);
    sb.note_pixel(r, g, b);
  endtask

  task automatic write_max(bit [COMP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.comp_max = value;
    settings++;
  endtask

  // drop valid and hold until every outstanding item has come back
  task automatic drain();
    rgb_ch.valid <= 1'b0;
    while (sb.pending_ypbpr.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic bit [COMP_W-1:0] pick_comp(bit [COMP_W-1:0] m);
    int k;
    k = $urandom_range(99);
    if (k < 10) return $urandom_range(1) ? m : '0;
    if (k < 85) return COMP_W'($urandom_range(m, 0));
    return COMP_W'($urandom_range(16'hFFFF, 0));
  endfunction

  task automatic run_phase(bit [COMP_W-1:0] m, int n, int send_idle, int recv_stall);
    bit [COMP_W-1:0] lim;
    write_max(m);
    gap_pct   = send_idle;
    stall_pct = recv_stall;
    lim = (m == 0) ? COMP_W'(1) : m;
    repeat (n) send_pixel(pick_comp(lim), pick_comp(lim), pick_comp(lim));
    drain();
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rgb_ch.valid     = 1'b0;
    rgb_ch.red       = '0;
    rgb_ch.green     = '0;
    rgb_ch.blue      = '0;
    ypbpr_ch.ready   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of component_max: primaries, secondaries, white, black, overrange
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd255, 16'd255, 16'd255);
    send_pixel(16'd255, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd255, 16'd0);
    send_pixel(16'd0, 16'd0, 16'd255);
    send_pixel(16'd255, 16'd255, 16'd0);
    send_pixel(16'd0, 16'd255, 16'd255);
    send_pixel(16'd255, 16'd0, 16'd255);
    send_pixel(16'hFFFF, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'd0, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // zero denominator behaves as one
    write_max(16'd0);
    send_pixel(16'd1, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd1, 16'd1);
    send_pixel(16'd2, 16'd3, 16'd4);
    send_pixel(16'd0, 16'd0, 16'd1);
    drain();

    write_max(16'hFFFF);
    send_pixel(16'hFFFF, 16'd0, 16'd0);
    send_pixel(16'd0, 16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'h8000, 16'h8000, 16'h8000);
    send_pixel(16'hAAAA, 16'h5555, 16'hFFFF);
    drain();

    run_phase(16'd255, 250, 0, 0);
    run_phase(16'hFFFF, 200, 86, 0);
    run_phase(16'd1, 150, 0, 86);
    run_phase(COMP_W'($urandom_range(16'hFFFF, 1)), 250, 13, 13);
    run_phase(16'd0, 100, 13, 13);
    run_phase(16'd1023, 200, 0, 0);
    run_phase(COMP_W'($urandom_range(4095, 2)), 100, 86, 0);
    run_phase(16'hFFFF, 100, 13, 13);

    if (sb.pending_ypbpr.size() != 0)
      $display("ERROR: %0d expected results never arrived", sb.pending_ypbpr.size());
    $display("Converted %0d pixels over %0d component_max settings, %0d results matched,",
             sb.pixels_in, settings, sb.results_ok);
    $display("%0d mismatches, %0d cycles with idle and stall mixes", sb.mismatches, cycles);
    if (sb.mismatches == 0 && sb.pending_ypbpr.size() == 0) begin
      $display("rgb_to_ypbpr_convert verification clean");
    end else begin
      $display("rgb_to_ypbpr_convert verification failed");
    end
    $finish;
  end

endmodule
